// ===== hw/rtl/tlbp_pkg.sv =====
// Package for the two-level branch predictor with BTB.
// Types, constants and the FSM state enum; no dependencies.
package tlbp_pkg;

  localparam int BtbEntriesDef = 16;
  localparam int MaxHistoryDef = 8;
  localparam int AddrW         = 3;

  localparam logic [AddrW-1:0] RegHistBits   = 3'd0;
  localparam logic [AddrW-1:0] RegCtrInit    = 3'd1;
  localparam logic [AddrW-1:0] RegGlobHist   = 3'd2;
  localparam logic [AddrW-1:0] RegGlobTable  = 3'd3;
  localparam logic [AddrW-1:0] RegShareMode  = 3'd4;

  localparam logic [1:0] ShareNone = 2'd0;
  localparam logic [1:0] SharePc2  = 2'd1;
  localparam logic [1:0] SharePc16 = 2'd2;

  // counter_init after reset; also the value every table yields after reset
  localparam logic [1:0] CtrInitRst = 2'd1;

  typedef struct packed {
    logic        func;
    logic [31:0] pc;
    logic [31:0] target_pc;
    logic        taken;
    logic [31:0] predicted_dst;
  } in_req_t;

  typedef struct packed {
    logic        pred_taken;
    logic [31:0] pred_target;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_OUT,
    ST_CLEAR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch request, launch table reads
    logic execute;   // compute result, write back state
    logic sweep;     // clear one counter memory slot
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wrap;        // this update wraps its row stamp, row must be swept
    logic sweep_last;  // sweep is at its last slot
  } sts_t;

endpackage

// ===== hw/rtl/tlbp_ctrl.sv =====
// Controller FSM for the branch predictor.
// Depends on tlbp_pkg.
module tlbp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tlbp_pkg::sts_t     sts,
  output tlbp_pkg::cmd_t     cmd
);

  tlbp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlbp_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlbp_pkg::ST_INIT: if (sts.sweep_last) state_nxt = tlbp_pkg::ST_IDLE;
      tlbp_pkg::ST_IDLE: if (in_valid) state_nxt = tlbp_pkg::ST_LOOK;
      tlbp_pkg::ST_LOOK: state_nxt = sts.wrap ? tlbp_pkg::ST_CLEAR : tlbp_pkg::ST_OUT;
      tlbp_pkg::ST_CLEAR: if (sts.sweep_last) state_nxt = tlbp_pkg::ST_OUT;
      tlbp_pkg::ST_OUT: begin
        if (out_ready) state_nxt = in_valid ? tlbp_pkg::ST_LOOK : tlbp_pkg::ST_IDLE;
      end
      default: state_nxt = tlbp_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.sweep   = 1'b0;
    unique case (state_r)
      tlbp_pkg::ST_INIT, tlbp_pkg::ST_CLEAR: cmd.sweep = 1'b1;
      tlbp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tlbp_pkg::ST_LOOK: cmd.execute = 1'b1;
      tlbp_pkg::ST_OUT: begin
        out_valid   = 1'b1;
        in_ready    = out_ready;
        cmd.capture = out_ready & in_valid;
      end
      default: ;
    endcase
  end

  a_out_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tlbp_pkg::ST_LOOK |=> (out_valid || state_r == tlbp_pkg::ST_CLEAR))
    else $error("no result after lookup");
  a_cap_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.execute)
    else $error("capture not followed by execute");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !((cmd.execute || cmd.sweep) && (in_ready || out_valid)))
    else $error("execute or sweep overlaps handshake");

endmodule

// ===== hw/rtl/tlbp_datapath.sv =====
// Datapath: BTB entries, histories, counter memories, counts.
// Depends on tlbp_pkg.
module tlbp_datapath #(
  parameter int BTB_ENTRIES = tlbp_pkg::BtbEntriesDef,
  parameter int MAX_HISTORY = tlbp_pkg::MaxHistoryDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tlbp_pkg::cmd_t      cmd,
  output tlbp_pkg::sts_t      sts,
  input  tlbp_pkg::in_req_t   in_data,
  output tlbp_pkg::out_req_t  out_data,
  input  logic [3:0]          history_bits,
  input  logic [1:0]          counter_init,
  input  logic                use_global_history,
  input  logic                use_global_table,
  input  logic [1:0]          share_mode
);

  localparam int IdxW   = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
  localparam int IdxB   = $clog2(BTB_ENTRIES);
  localparam int TagW   = 30 - IdxB;
  localparam int Depth  = 1 << MAX_HISTORY;
  localparam int RowW   = (BTB_ENTRIES > 1) ? IdxW + MAX_HISTORY : MAX_HISTORY;

  // Per-entry counter rows: each row has a refill value plus a generation
  // stamp; a slot counts only if written in the row's current generation.
  // The memory is swept clear after reset, and a row is swept when its
  // stamp wraps, so stale slots never match.
  logic              vld_r  [BTB_ENTRIES];
  logic [TagW-1:0]   tag_r  [BTB_ENTRIES];
  logic [31:0]       tgt_r  [BTB_ENTRIES];
  logic [MAX_HISTORY-1:0] lhist_r [BTB_ENTRIES];
  logic [MAX_HISTORY-1:0] ghist_r;
  logic [1:0]        rinit_r [BTB_ENTRIES];  // refill value per row
  logic [7:0]        rgen_r  [BTB_ENTRIES];  // row generation
  logic [31:0]       bcnt_r, fcnt_r;

  // shared table: valid bits (2^MAX_HISTORY entries, 256 by default)
  logic [Depth-1:0]  sh_vld_r;
  logic [1:0]        sh_init_r;
  logic [1:0]        sh_mem [Depth];
  logic [1:0]        sh_rd_r;

  // entry table: counter + generation stamp + written flag
  logic [10:0]       en_mem [BTB_ENTRIES*Depth];
  logic [10:0]       en_rd_r;
  logic [BTB_ENTRIES-1:0] en_any_r; // row has ever been allocated/refilled

  // sweep of the entry table
  logic [RowW-1:0]        sw_addr_r;
  logic                   sw_row_r;   // 1: one row, 0: whole table
  logic [MAX_HISTORY-1:0] sw_skip_r;  // slot just written, kept
  logic                   sw_last;
  logic                   row_wrap;

  tlbp_pkg::in_req_t req_r;
  logic [MAX_HISTORY-1:0] hidx_r;
  tlbp_pkg::out_req_t out_r;

  // history mask
  logic [3:0] hlen;
  logic [MAX_HISTORY-1:0] hmask;
  always_comb begin
    hlen = history_bits;
    if (hlen < 4'd1) hlen = 4'd1;
    if (hlen > 4'(MAX_HISTORY)) hlen = 4'(MAX_HISTORY);
    hmask = MAX_HISTORY'((9'd1 << hlen) - 9'd1);
  end

  // index computation on the incoming request
  logic [IdxW-1:0] in_idx;
  logic [TagW-1:0] in_tag;
  logic in_hit;
  logic [MAX_HISTORY-1:0] in_h;
  assign in_idx = (BTB_ENTRIES > 1) ? IdxW'(in_data.pc[2 +: IdxW]) : '0;
  assign in_tag = in_data.pc[31 -: TagW];
  assign in_hit = vld_r[in_idx] && (tag_r[in_idx] == in_tag);
  always_comb begin
    if (use_global_history) in_h = ghist_r;
    else if (in_data.func && !in_hit) in_h = '0;
    else in_h = lhist_r[in_idx];
    if (use_global_table) begin
      case (share_mode)
        tlbp_pkg::SharePc2:  in_h = in_h ^ in_data.pc[2 +: MAX_HISTORY];
        tlbp_pkg::SharePc16: in_h = in_h ^ in_data.pc[16 +: MAX_HISTORY];
        default: ;
      endcase
    end
    in_h = in_h & hmask;
  end

  logic [RowW-1:0] in_addr;
  assign in_addr = (BTB_ENTRIES > 1) ? RowW'({in_idx, in_h}) : RowW'(in_h);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_data;
      hidx_r  <= in_h;
      sh_rd_r <= sh_mem[in_h];
      en_rd_r <= en_mem[in_addr];
    end
  end

  // execute stage
  logic [IdxW-1:0] x_idx;
  logic [TagW-1:0] x_tag;
  logic x_hit, x_miss_upd;
  logic [1:0] ctr, ctr_new;
  logic [31:0] pc4;
  logic [RowW-1:0] x_addr;
  logic [7:0] x_gen;
  assign x_idx = (BTB_ENTRIES > 1) ? IdxW'(req_r.pc[2 +: IdxW]) : '0;
  assign x_tag = req_r.pc[31 -: TagW];
  assign x_hit = vld_r[x_idx] && (tag_r[x_idx] == x_tag);
  assign x_miss_upd = req_r.func && !x_hit;
  assign pc4 = req_r.pc + 32'd4;
  assign x_addr = (BTB_ENTRIES > 1) ? RowW'({x_idx, hidx_r}) : RowW'(hidx_r);
  assign x_gen = (x_miss_upd && !use_global_table) ? rgen_r[x_idx] + 8'd1
                                                   : rgen_r[x_idx];

  // a refill that takes the stamp back to zero needs the row swept
  assign row_wrap = x_miss_upd && !use_global_table && (rgen_r[x_idx] == 8'hFF);
  assign sw_last  = sw_row_r ? (&sw_addr_r[MAX_HISTORY-1:0]) : (&sw_addr_r);
  assign sts      = '{wrap: row_wrap, sweep_last: sw_last};

  always_comb begin
    if (use_global_table) begin
      ctr = sh_vld_r[hidx_r] ? sh_rd_r : sh_init_r;
    end else if (x_miss_upd) begin
      ctr = counter_init;
    end else if (en_rd_r[2] && en_rd_r[10:3] == rgen_r[x_idx]) begin
      ctr = en_rd_r[1:0];
    end else if (en_any_r[x_idx]) begin
      ctr = rinit_r[x_idx];
    end else begin
      ctr = sh_init_r;
    end
    if (req_r.taken) ctr_new = (ctr == 2'd3) ? ctr : ctr + 2'd1;
    else             ctr_new = (ctr == 2'd0) ? ctr : ctr - 2'd1;
  end

  logic mispred;
  assign mispred = req_r.taken ? (req_r.predicted_dst != req_r.target_pc)
                               : (req_r.predicted_dst != pc4);

  logic [MAX_HISTORY-1:0] lh_base, hist_new;
  assign lh_base  = use_global_history ? ghist_r
                  : (x_miss_upd ? '0 : lhist_r[x_idx]);
  assign hist_new = MAX_HISTORY'({lh_base, req_r.taken}) & hmask;

  always_ff @(posedge clk) begin
    if (cmd.sweep && (!sw_row_r || sw_addr_r[MAX_HISTORY-1:0] != sw_skip_r)) begin
      en_mem[sw_addr_r] <= '0;
    end
    if (cmd.execute && req_r.func) begin
      if (use_global_table) sh_mem[hidx_r] <= ctr_new;
      else en_mem[x_addr] <= {x_gen, 1'b1, ctr_new};
      tgt_r[x_idx] <= req_r.target_pc;
      if (x_miss_upd) tag_r[x_idx] <= x_tag;
      if (x_miss_upd && !use_global_table) rinit_r[x_idx] <= counter_init;
    end
    if (cmd.execute) begin
      out_r.pred_taken  <= !req_r.func && x_hit && ctr[1];
      out_r.pred_target <= req_r.func ? 32'd0
                         : ((x_hit && ctr[1]) ? tgt_r[x_idx] : pc4);
      out_r.branch_count <= bcnt_r + {31'd0, req_r.func};
      out_r.flush_count  <= fcnt_r + {31'd0, req_r.func & mispred};
    end
  end

  // sweep address: whole table after reset, one row on a stamp wrap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_addr_r <= '0;
      sw_row_r  <= 1'b0;
      sw_skip_r <= '0;
    end else if (cmd.execute && row_wrap) begin
      sw_addr_r <= (BTB_ENTRIES > 1) ? RowW'({x_idx, {MAX_HISTORY{1'b0}}}) : '0;
      sw_row_r  <= 1'b1;
      sw_skip_r <= hidx_r;
    end else if (cmd.sweep) begin
      sw_addr_r <= sw_addr_r + RowW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BTB_ENTRIES; i++) begin
        vld_r[i]   <= 1'b0;
        lhist_r[i] <= '0;
        rgen_r[i]  <= '0;
      end
      ghist_r   <= '0;
      sh_vld_r  <= '0;
      sh_init_r <= tlbp_pkg::CtrInitRst;
      en_any_r  <= '0;
      bcnt_r    <= '0;
      fcnt_r    <= '0;
    end else if (cmd.execute && req_r.func) begin
      vld_r[x_idx] <= 1'b1;
      if (use_global_history) ghist_r <= hist_new;
      else lhist_r[x_idx] <= hist_new;
      if (use_global_table) sh_vld_r[hidx_r] <= 1'b1;
      else if (x_miss_upd) begin
        rgen_r[x_idx]   <= x_gen;
        en_any_r[x_idx] <= 1'b1;
      end
      bcnt_r <= bcnt_r + 32'd1;
      if (mispred) fcnt_r <= fcnt_r + 32'd1;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/two_level_branch_predictor_btb_top.sv =====
// Top level of the two-level branch predictor with BTB.
// Uses tlbp_pkg, tlbp_ctrl, tlbp_datapath.
//
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready  | in_data  (in_req_t)
// out_    | output    | out_valid / out_ready| out_data (out_req_t)
// cfg_    | input     | APB psel/penable     | 32-bit register write/read
//
// Each request reads the counter memory and then updates it
// (read-modify-write on the single-port table).
// A new request is taken in the cycle its predecessor's result leaves.
// Reset is synchronous; afterwards the entry counter memory is swept clear
// before a request is taken. A refill that wraps a row's stamp adds a
// sweep of that row before its result is offered.
// A stalled result holds; no further request is taken until it leaves.
module two_level_branch_predictor_btb_top #(
  parameter int BTB_ENTRIES = tlbp_pkg::BtbEntriesDef,
  parameter int MAX_HISTORY = tlbp_pkg::MaxHistoryDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlbp_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlbp_pkg::out_req_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [tlbp_pkg::AddrW+1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [3:0] hist_bits_r;
  logic [1:0] ctr_init_r;
  logic       glob_hist_r, glob_tab_r;
  logic [1:0] share_r;
  logic [tlbp_pkg::AddrW-1:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel = cfg_paddr[tlbp_pkg::AddrW+1:2];

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_bits_r <= 4'd2;
      ctr_init_r  <= tlbp_pkg::CtrInitRst;
      glob_hist_r <= 1'b0;
      glob_tab_r  <= 1'b0;
      share_r     <= tlbp_pkg::ShareNone;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_sel)
        tlbp_pkg::RegHistBits:  hist_bits_r <= cfg_pwdata[3:0];
        tlbp_pkg::RegCtrInit:   ctr_init_r  <= cfg_pwdata[1:0];
        tlbp_pkg::RegGlobHist:  glob_hist_r <= cfg_pwdata[0];
        tlbp_pkg::RegGlobTable: glob_tab_r  <= cfg_pwdata[0];
        tlbp_pkg::RegShareMode: share_r     <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    unique case (reg_sel)
      tlbp_pkg::RegHistBits:  cfg_prdata = {28'd0, hist_bits_r};
      tlbp_pkg::RegCtrInit:   cfg_prdata = {30'd0, ctr_init_r};
      tlbp_pkg::RegGlobHist:  cfg_prdata = {31'd0, glob_hist_r};
      tlbp_pkg::RegGlobTable: cfg_prdata = {31'd0, glob_tab_r};
      tlbp_pkg::RegShareMode: cfg_prdata = {30'd0, share_r};
      default: ;
    endcase
  end

  tlbp_pkg::cmd_t cmd;
  tlbp_pkg::sts_t sts;

  tlbp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  tlbp_datapath #(.BTB_ENTRIES(BTB_ENTRIES), .MAX_HISTORY(MAX_HISTORY)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_data, .out_data,
    .history_bits(hist_bits_r), .counter_init(ctr_init_r),
    .use_global_history(glob_hist_r), .use_global_table(glob_tab_r),
    .share_mode(share_r)
  );

endmodule
